// File: rtl/pwmt_pkg.sv
// Shared types and constants of the PWM timer peripheral core.
// Used by the top level and the compare channel module; no dependencies.
`timescale 1ns / 1ps

package pwmt_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [3:0] REG_CTRL   = 4'd0;
    localparam logic [3:0] REG_IER    = 4'd1;
    localparam logic [3:0] REG_STATUS = 4'd2;
    localparam logic [3:0] REG_EGR    = 4'd3;
    localparam logic [3:0] REG_MODE_L = 4'd4;
    localparam logic [3:0] REG_MODE_H = 4'd5;
    localparam logic [3:0] REG_OE     = 4'd6;
    localparam logic [3:0] REG_COUNT  = 4'd7;
    localparam logic [3:0] REG_PSC    = 4'd8;
    localparam logic [3:0] REG_ARR    = 4'd9;
    localparam logic [3:0] REG_CMP1   = 4'd10;
    localparam logic [3:0] REG_CMP2   = 4'd11;
    localparam logic [3:0] REG_CMP3   = 4'd12;
    localparam logic [3:0] REG_CMP4   = 4'd13;

    localparam int CR_CEN  = 0;
    localparam int CR_UDIS = 1;
    localparam int CR_URS  = 2;
    localparam int CR_OPM  = 3;
    localparam int CR_ARPE = 7;

    localparam logic [2:0] MODE_PWM1       = 3'b110;
    localparam logic [2:0] MODE_PWM2       = 3'b111;
    localparam logic [2:0] MODE_FORCE_HIGH = 3'b101;

    typedef struct packed {
        logic cmp_write;
        logic transfer;
        logic step;
    } chan_ctrl_t;

endpackage

// File: rtl/pwm_timer_peripheral_core.sv
// Top level of the PWM timer peripheral core: command register, timer state
// and register file, result register. Depends on pwmt_pkg and pwmt_channel.
`timescale 1ns / 1ps

// Each transaction is a register read, a register write or one timer tick.
// The core takes one transaction every clock cycle while no stalled result
// holds it back. A transaction is held in the command register, and its
// result is registered into the result register as it leaves. All state
// updates are made in a single pass between the two registers. A result
// waiting on a stalled response channel holds back only the command register,
// so the core keeps taking transactions until both registers are full.
// COUNT_WIDTH sets the counter, reload and compare widths; CHANNEL_COUNT sets
// how many compare channels exist, and absent channels read zero and drive a
// low output.

module pwm_timer_peripheral_core #(
    parameter int COUNT_WIDTH   = 16,
    parameter int CHANNEL_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  operation,
    input  logic [3:0]  reg_index,
    input  logic [15:0] write_data,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [15:0] read_data,
    output logic        irq,
    output logic [3:0]  pwm_out,
    output logic        update_event
);
    import pwmt_pkg::*;

    localparam logic [3:0] CHAN_MASK = 4'((1 << CHANNEL_COUNT) - 1);

    logic        cmd_valid_reg;
    logic        cmd_valid_next;
    logic [1:0]  op_reg;
    logic [3:0]  idx_reg;
    logic [15:0] data_reg;
    logic        fire;

    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic [15:0] read_data_reg;
    logic        irq_reg;
    logic [3:0]  pwm_out_reg;
    logic        update_event_reg;

    logic [7:0]  ctrl_reg;
    logic [7:0]  ctrl_next;
    logic [4:0]  ier_reg;
    logic [4:0]  ier_next;
    logic [4:0]  sr_reg;
    logic [4:0]  sr_base;
    logic [4:0]  sr_next;
    logic [15:0] mode_low_reg;
    logic [15:0] mode_low_next;
    logic [15:0] mode_high_reg;
    logic [15:0] mode_high_next;
    logic [15:0] oe_reg;
    logic [15:0] oe_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [15:0] psc_cnt_reg;
    logic [15:0] psc_cnt_next;
    logic [15:0] psc_pre_reg;
    logic [15:0] psc_pre_next;
    logic [15:0] psc_act_reg;
    logic [15:0] psc_act_next;
    logic [COUNT_WIDTH-1:0] arr_pre_reg;
    logic [COUNT_WIDTH-1:0] arr_pre_next;
    logic [COUNT_WIDTH-1:0] arr_act_reg;
    logic [COUNT_WIDTH-1:0] arr_act_next;

    logic        uev;
    logic        transfer;
    logic        step;
    logic [15:0] rd_value;
    logic [3:0]  chan_match;
    logic [3:0]  chan_level;
    logic [COUNT_WIDTH-1:0] chan_read [4];

    assign fire           = cmd_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall      = cmd_valid_reg && !fire;
    assign cmd_valid_next = (cmd_valid && !cmd_stall) ? 1'b1 : (fire ? 1'b0 : cmd_valid_reg);
    assign rsp_valid_next = fire ? 1'b1 : (rsp_stall ? rsp_valid_reg : 1'b0);

    always_comb
    begin
        ctrl_next      = ctrl_reg;
        ier_next       = ier_reg;
        sr_base        = sr_reg;
        mode_low_next  = mode_low_reg;
        mode_high_next = mode_high_reg;
        oe_next        = oe_reg;
        count_next     = count_reg;
        psc_cnt_next   = psc_cnt_reg;
        psc_pre_next   = psc_pre_reg;
        psc_act_next   = psc_act_reg;
        arr_pre_next   = arr_pre_reg;
        arr_act_next   = arr_act_reg;
        uev            = 1'b0;
        transfer       = 1'b0;
        step           = 1'b0;
        rd_value       = '0;

        if (fire && (op_reg == OP_TICK) && ctrl_reg[CR_CEN])
        begin
            if (psc_cnt_reg < psc_act_reg)
            begin
                psc_cnt_next = psc_cnt_reg + 16'd1;
            end
            else
            begin
                psc_cnt_next = '0;
                if (arr_act_reg != '0)
                begin
                    step = 1'b1;
                    if (count_reg >= arr_act_reg)
                    begin
                        count_next = '0;
                        if (!ctrl_reg[CR_UDIS])
                        begin
                            uev        = 1'b1;
                            transfer   = 1'b1;
                            sr_base[0] = 1'b1;
                            if (ctrl_reg[CR_OPM])
                            begin
                                ctrl_next[CR_CEN] = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_WIDTH'(1);
                    end
                end
            end
        end

        if (fire && (op_reg == OP_WRITE))
        begin
            unique case (idx_reg)
                REG_CTRL:   ctrl_next = data_reg[7:0];
                REG_IER:    ier_next = data_reg[4:0];
                REG_STATUS: sr_base = sr_reg & data_reg[4:0];
                REG_EGR:
                begin
                    if (data_reg[0])
                    begin
                        count_next   = '0;
                        psc_cnt_next = '0;
                        if (!ctrl_reg[CR_UDIS])
                        begin
                            uev      = 1'b1;
                            transfer = 1'b1;
                            if (!ctrl_reg[CR_URS])
                            begin
                                sr_base[0] = 1'b1;
                            end
                        end
                    end
                    sr_base[4:1] = sr_base[4:1] | (data_reg[4:1] & CHAN_MASK);
                end
                REG_MODE_L: mode_low_next = data_reg;
                REG_MODE_H: mode_high_next = data_reg;
                REG_OE:     oe_next = data_reg;
                REG_COUNT:  count_next = COUNT_WIDTH'(data_reg);
                REG_PSC:    psc_pre_next = data_reg;
                REG_ARR:
                begin
                    arr_pre_next = COUNT_WIDTH'(data_reg);
                    if (!ctrl_reg[CR_ARPE])
                    begin
                        arr_act_next = COUNT_WIDTH'(data_reg);
                    end
                end
                default:    ;
            endcase
        end

        if (transfer)
        begin
            psc_act_next = psc_pre_reg;
            arr_act_next = arr_pre_reg;
        end

        if (op_reg == OP_READ)
        begin
            unique case (idx_reg)
                REG_CTRL:   rd_value = {8'd0, ctrl_reg};
                REG_IER:    rd_value = {11'd0, ier_reg};
                REG_STATUS: rd_value = {11'd0, sr_reg};
                REG_MODE_L: rd_value = mode_low_reg;
                REG_MODE_H: rd_value = mode_high_reg;
                REG_OE:     rd_value = oe_reg;
                REG_COUNT:  rd_value = 16'(count_reg);
                REG_PSC:    rd_value = psc_pre_reg;
                REG_ARR:    rd_value = 16'(arr_pre_reg);
                REG_CMP1:   rd_value = 16'(chan_read[0]);
                REG_CMP2:   rd_value = 16'(chan_read[1]);
                REG_CMP3:   rd_value = 16'(chan_read[2]);
                REG_CMP4:   rd_value = 16'(chan_read[3]);
                default:    rd_value = '0;
            endcase
        end
    end

    assign sr_next = sr_base | {chan_match, 1'b0};

    for (genvar k = 0; k < 4; k++)
    begin : g_chan
        if (k < CHANNEL_COUNT)
        begin : g_on
            chan_ctrl_t ch_ctrl;
            logic [7:0] mode_cur;
            logic [7:0] mode_new;

            assign mode_cur = (k < 2) ? mode_low_reg[8*(k%2) +: 8]
                                      : mode_high_reg[8*(k%2) +: 8];
            assign mode_new = (k < 2) ? mode_low_next[8*(k%2) +: 8]
                                      : mode_high_next[8*(k%2) +: 8];
            assign ch_ctrl.cmp_write = fire && (op_reg == OP_WRITE)
                                       && (idx_reg == 4'(REG_CMP1 + k));
            assign ch_ctrl.transfer  = transfer;
            assign ch_ctrl.step      = step;

            pwmt_channel #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_channel (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ch_ctrl),
                .cmp_data  (COUNT_WIDTH'(data_reg)),
                .mode_cur  (mode_cur),
                .mode_new  (mode_new),
                .out_en    (oe_next[4*k]),
                .out_inv   (oe_next[4*k+1]),
                .count_new (count_next),
                .level     (chan_level[k]),
                .match     (chan_match[k]),
                .cmp_read  (chan_read[k])
            );
        end
        else
        begin : g_off
            assign chan_level[k] = 1'b0;
            assign chan_match[k] = 1'b0;
            assign chan_read[k]  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            ctrl_reg      <= '0;
            ier_reg       <= '0;
            sr_reg        <= '0;
            mode_low_reg  <= '0;
            mode_high_reg <= '0;
            oe_reg        <= '0;
            count_reg     <= '0;
            psc_cnt_reg   <= '0;
            psc_pre_reg   <= '0;
            psc_act_reg   <= '0;
            arr_pre_reg   <= '1;
            arr_act_reg   <= '1;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            ctrl_reg      <= ctrl_next;
            ier_reg       <= ier_next;
            sr_reg        <= sr_next;
            mode_low_reg  <= mode_low_next;
            mode_high_reg <= mode_high_next;
            oe_reg        <= oe_next;
            count_reg     <= count_next;
            psc_cnt_reg   <= psc_cnt_next;
            psc_pre_reg   <= psc_pre_next;
            psc_act_reg   <= psc_act_next;
            arr_pre_reg   <= arr_pre_next;
            arr_act_reg   <= arr_act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            op_reg   <= operation;
            idx_reg  <= reg_index;
            data_reg <= write_data;
        end
        if (fire)
        begin
            read_data_reg    <= rd_value;
            irq_reg          <= |(sr_next & ier_next);
            pwm_out_reg      <= chan_level;
            update_event_reg <= uev;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign read_data    = read_data_reg;
    assign irq          = irq_reg;
    assign pwm_out      = pwm_out_reg;
    assign update_event = update_event_reg;

endmodule

// File: rtl/pwmt_channel.sv
// One compare channel: compare preload and active registers, match detection
// and PWM output level. Depends on pwmt_pkg.
`timescale 1ns / 1ps

module pwmt_channel #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pwmt_pkg::chan_ctrl_t     ctrl,
    input  logic [COUNT_WIDTH-1:0]   cmp_data,
    input  logic [7:0]               mode_cur,
    input  logic [7:0]               mode_new,
    input  logic                     out_en,
    input  logic                     out_inv,
    input  logic [COUNT_WIDTH-1:0]   count_new,
    output logic                     level,
    output logic                     match,
    output logic [COUNT_WIDTH-1:0]   cmp_read
);
    import pwmt_pkg::*;

    logic [COUNT_WIDTH-1:0] preload_reg;
    logic [COUNT_WIDTH-1:0] preload_next;
    logic [COUNT_WIDTH-1:0] active_reg;
    logic [COUNT_WIDTH-1:0] active_next;
    logic                   below;
    logic                   ref_level;

    always_comb
    begin
        preload_next = preload_reg;
        active_next  = active_reg;
        if (ctrl.cmp_write)
        begin
            preload_next = cmp_data;
            if (!mode_cur[3])
            begin
                active_next = cmp_data;
            end
        end
        if (ctrl.transfer && mode_cur[3])
        begin
            active_next = preload_reg;
        end
    end

    assign below = count_new < active_next;
    assign match = ctrl.step && (mode_cur[1:0] == 2'b00) && (count_new == active_next);

    always_comb
    begin
        ref_level = 1'b0;
        if (mode_new[1:0] == 2'b00)
        begin
            priority if (mode_new[6:4] == MODE_PWM1)
            begin
                ref_level = below;
            end
            else if (mode_new[6:4] == MODE_PWM2)
            begin
                ref_level = !below;
            end
            else if (mode_new[6:4] == MODE_FORCE_HIGH)
            begin
                ref_level = 1'b1;
            end
            else
            begin
                ref_level = 1'b0;
            end
        end
    end

    assign level    = out_en && (ref_level ^ out_inv);
    assign cmp_read = preload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preload_reg <= '0;
            active_reg  <= '0;
        end
        else
        begin
            preload_reg <= preload_next;
            active_reg  <= active_next;
        end
    end

endmodule

// File: rtl/pwmt_checker.sv
// Port-level checks of the PWM timer peripheral core, bound to its top level.
// Depends only on the ports of pwm_timer_peripheral_core.
`timescale 1ns / 1ps

module pwmt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_stall,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [15:0] read_data,
    input logic        irq,
    input logic [3:0]  pwm_out,
    input logic        update_event
);

    // With no result pending, the core must be able to take a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !cmd_stall)
    else $error("command stalled while the result register is empty");

    // A transaction accepted, with the response side open while it sits in the command register, yields a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) ##1 !rsp_stall |=> rsp_valid)
    else $error("accepted transaction produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> rsp_valid
            && $stable(read_data) && $stable(irq)
            && $stable(pwm_out) && $stable(update_event))
    else $error("stalled result changed or was dropped");

endmodule

bind pwm_timer_peripheral_core pwmt_checker u_pwmt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .read_data    (read_data),
    .irq          (irq),
    .pwm_out      (pwm_out),
    .update_event (update_event)
);
